### rtl/acmac_pkg.sv
// Shared types, constants and AES helper functions for the CMAC tag engine.
package acmac_pkg;

    localparam int unsigned KeyWidth   = 64;
    localparam int unsigned BlockWidth = 128;
    localparam int unsigned QueueDepth = 4;
    localparam logic [7:0]  CmacRb     = 8'h87;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1
    } cfg_idx_t;

    // Work item handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_CHAIN  = 2'd0,   // encrypt chain ^ block
        OP_TAG_K1 = 2'd1,   // full last block
        OP_TAG_K2 = 2'd2    // padded last block
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BlockWidth-1:0] block;
    } job_t;

    localparam logic [7:0] SBOX [256] = '{
     8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
     8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
     8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
     8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
     8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
     8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
     8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
     8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
     8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
     8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
     8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
     8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
     8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
     8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
     8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
     8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits 127-8i .. 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        get_byte = b[127-8*i -: 8];
    endfunction

    // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                t[j+4*c] = SBOX[get_byte(s, j + 4*((c + j) % 4))];
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = t[i];
        aes_round = r ^ rk;
    endfunction

    // Next round key from the current one.
    function automatic logic [127:0] key_step(input logic [127:0] k,
                                              input logic [7:0]   rcon);
        logic [31:0] w0, w1, w2, w3, g;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        g  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ g;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] blk_mul_x(input logic [127:0] v);
        blk_mul_x = {v[126:0], 1'b0} ^ (v[127] ? {120'd0, CmacRb} : 128'd0);
    endfunction

endpackage

### rtl/acmac_front.sv
// Front part: gathers bytes into blocks and issues block jobs to the queue.
module acmac_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clear,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [7:0]                      data_byte,
    output logic                            job_valid,
    input  logic                            job_ready,
    output acmac_pkg::job_t                 job
);
    import acmac_pkg::*;

    logic [127:0] buf_reg, buf_next;
    logic [4:0]   fill_reg, fill_next;
    logic [127:0] padded;
    logic         full;

    assign full = fill_reg[4];

    // Pad mask: bytes below fill kept, 0x80 at fill, zeros after.
    always_comb
    begin
        padded = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (i < fill_reg)
                padded[127-8*i -: 8] = buf_reg[127-8*i -: 8];
            else if (i == fill_reg)
                padded[127-8*i -: 8] = 8'h80;
        end
    end

    // An absorb into a full buffer and every finish need a queue slot.
    always_comb
    begin
        job_valid = 1'b0;
        job.op    = OP_CHAIN;
        job.block = buf_reg;
        if (in_valid)
        begin
            if (command == CMD_FINISH)
            begin
                job_valid = 1'b1;
                job.op    = full ? OP_TAG_K1 : OP_TAG_K2;
                job.block = full ? buf_reg : padded;
            end
            else if (full)
            begin
                job_valid = 1'b1;
            end
        end
    end

    assign in_ready = !job_valid || job_ready;

    always_comb
    begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        if (in_valid && in_ready)
        begin
            if (command == CMD_FINISH)
            begin
                fill_next = '0;
            end
            else
            begin
                if (full)
                begin
                    buf_next  = {data_byte, 120'd0};
                    fill_next = 5'd1;
                end
                else
                begin
                    buf_next[127 - 8*fill_reg[3:0] -: 8] = data_byte;
                    fill_next = fill_reg + 5'd1;
                end
            end
        end
        if (clear)
            fill_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

### rtl/acmac_queue.sv
// Small FIFO of block jobs between the front and back parts.
module acmac_queue
#(
    parameter int unsigned Depth = acmac_pkg::QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            push,
    output logic            can_push,
    input  acmac_pkg::job_t push_job,
    output logic            pop_valid,
    input  logic            pop,
    output acmac_pkg::job_t pop_job
);
    import acmac_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    job_t              mem_reg [Depth];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;
    logic              do_push, do_pop;

    assign can_push  = (cnt_reg != (AW+1)'(Depth));
    assign pop_valid = (cnt_reg != '0);
    assign pop_job   = mem_reg[rd_reg];
    assign do_push   = push && can_push;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == AW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == AW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

### rtl/acmac_back.sv
// Back part: iterative AES-128 core, subkey derivation and chaining value.
module acmac_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic [127:0]     key,
    input  logic             job_valid,
    output logic             job_pop,
    input  acmac_pkg::job_t  job,
    output logic             tvalid,
    input  logic             tready,
    output logic [127:0]     tag
);
    import acmac_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SUBKEY = 4'b0010,
        ST_ROUND  = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic [3:0]   round_reg, round_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] k1_reg, k1_next, k2_reg, k2_next;
    logic         ready_reg, ready_next;
    logic         tag_op_reg, tag_op_next;
    logic         out_v_reg, out_v_next;
    logic [127:0] out_reg, out_next;
    logic [127:0] rk_new, rnd, sk, blk;

    assign rk_new = key_step(rk_reg, rcon_reg);
    assign rnd    = aes_round(st_reg, rk_new, round_reg == 4'd10);
    assign sk     = (job.op == OP_TAG_K1) ? k1_reg :
                    (job.op == OP_TAG_K2) ? k2_reg : '0;
    assign blk    = chain_reg ^ job.block ^ sk;
    assign tvalid = out_v_reg;
    assign tag    = out_reg;

    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        rcon_next   = rcon_reg;
        st_next     = st_reg;
        rk_next     = rk_reg;
        chain_next  = chain_reg;
        k1_next     = k1_reg;
        k2_next     = k2_reg;
        ready_next  = ready_reg;
        tag_op_next = tag_op_reg;
        out_v_next  = out_v_reg && !tready;
        out_next    = out_reg;
        job_pop     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && !ready_reg)
                begin
                    // Derive L = E(K, 0) before first use of the key.
                    state_next = ST_SUBKEY;
                    st_next    = key;
                    rk_next    = key;
                    rcon_next  = 8'h01;
                    round_next = 4'd1;
                end
                else if (job_valid && (job.op == OP_CHAIN || !out_v_next))
                begin
                    job_pop     = 1'b1;
                    state_next  = ST_ROUND;
                    st_next     = blk ^ key;
                    rk_next     = key;
                    rcon_next   = 8'h01;
                    round_next  = 4'd1;
                    tag_op_next = (job.op != OP_CHAIN);
                end
            end
            ST_SUBKEY, ST_ROUND:
            begin
                st_next    = rnd;
                rk_next    = rk_new;
                rcon_next  = xtime(rcon_reg);
                round_next = round_reg + 4'd1;
                if (round_reg == 4'd10)
                begin
                    state_next = ST_IDLE;
                    if (state_reg == ST_SUBKEY)
                    begin
                        k1_next    = blk_mul_x(rnd);
                        k2_next    = blk_mul_x(blk_mul_x(rnd));
                        ready_next = 1'b1;
                    end
                    else if (tag_op_reg)
                    begin
                        if (out_v_next)
                        begin
                            state_next = ST_HOLD;
                            st_next    = rnd;
                        end
                        else
                        begin
                            out_v_next = 1'b1;
                            out_next   = rnd;
                        end
                        chain_next = '0;
                    end
                    else
                    begin
                        chain_next = rnd;
                    end
                end
            end
            ST_HOLD:
            begin
                if (!out_v_next)
                begin
                    out_v_next = 1'b1;
                    out_next   = st_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (clear)
        begin
            ready_next = 1'b0;
            chain_next = '0;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            out_v_reg <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            out_v_reg <= out_v_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg  <= round_next;
        rcon_reg   <= rcon_next;
        st_reg     <= st_next;
        rk_reg     <= rk_next;
        k1_reg     <= k1_next;
        k2_reg     <= k2_next;
        tag_op_reg <= tag_op_next;
        out_reg    <= out_next;
    end

endmodule

### rtl/aes_cmac_tag_engine.sv
// Top level of the AES-128 CMAC tag engine.
// Usage:
//  - Write key_high (index 0) and key_low (index 1) through cfg_we/cfg_index/
//    cfg_data while idle; a key write discards any message in progress.
//  - Slave stream: one transfer per item; tuser = command (0 absorb byte,
//    1 finish), tdata = data byte.
//  - Master stream: one transfer per finish, tdata = {tag_low, tag_high}
//    with tag_high in bits 63:0.
// Timing: input takes one byte per cycle while the job queue has room. A full
//  block goes to the job queue when the next byte arrives; the iterative AES
//  unit (one round per clock) works on one block or finish at a time, so
//  long messages keep pace with input while runs of short messages stall
//  input once the queue fills. The first job after a key write also waits
//  for subkey derivation.
// Reset clears buffer fill, chaining value and subkey state; no clearing pass.
// If the receiver stalls, the tag waits in an output register; the next tag
//  parks in the AES unit, which then stops, and input stalls once the queue fills.
module aes_cmac_tag_engine
#(
    parameter int unsigned JobDepth = acmac_pkg::QueueDepth
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] tag_high, [127:64] tag_low
);
    import acmac_pkg::*;

    logic [63:0]  key_hi_reg, key_lo_reg;
    logic         clear;
    logic         f_valid, q_can_push, q_valid, q_pop;
    job_t         f_job, q_job;
    logic [127:0] tag;

    // Any key write resets subkeys and message state.
    assign clear = cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(CFG_KEY_HIGH))
                key_hi_reg <= cfg_data;
            else
                key_lo_reg <= cfg_data;
        end
    end

    acmac_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .command   (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .job_valid (f_valid),
        .job_ready (q_can_push),
        .job       (f_job)
    );

    acmac_queue #(.Depth(JobDepth)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .push      (f_valid),
        .can_push  (q_can_push),
        .push_job  (f_job),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_job   (q_job)
    );

    acmac_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .key       ({key_hi_reg, key_lo_reg}),
        .job_valid (q_valid),
        .job_pop   (q_pop),
        .job       (q_job),
        .tvalid    (m_axis_tvalid),
        .tready    (m_axis_tready),
        .tag       (tag)
    );

    assign m_axis_tdata = {tag[63:0], tag[127:64]};

`ifndef SYNTHESIS
    // Front never offers a job the queue cannot take while accepting input.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && f_valid) |-> q_can_push)
        else $error("job lost at queue");
    // A pending tag is never overwritten before it is taken.
    a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("tag changed while stalled");
    // The back part pops only when the queue holds a job.
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule
